### src/ibfd_pkg.sv
package ibfd_pkg;

   localparam int unsigned CHANNEL_COUNT_DEF = 14;
   localparam int unsigned FRAME_BYTES_DEF   = 32;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned VALUE_W   = 16;
   localparam int unsigned CHANNEL_W = 4;
   localparam int unsigned POS_W     = 5;

   localparam logic [VALUE_W-1:0] SUM_INIT = 16'hFFFF;

   // Command queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              frame_start;
   } req_item_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel_index;
      logic [VALUE_W-1:0]   channel_value;
      logic                 last_channel;
   } rsp_item_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EMIT  = 1'b1
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type           op;
      logic [CHANNEL_W-1:0] index;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

endpackage

### src/ibfd_front.sv
module ibfd_front #(
   parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEF,
   parameter int unsigned FRAME_BYTES   = ibfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ibfd_pkg::req_item_type req_item,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output ibfd_pkg::cmd_type     cmd
);
   import ibfd_pkg::*;

   localparam logic [POS_W-1:0] PAYLOAD_END = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W:0]   CHAN_END    = (POS_W + 1)'(2 + 2 * CHANNEL_COUNT);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0]  hold_ff, hold_in;

   logic [POS_W-1:0]   pos;
   logic [VALUE_W-1:0] sum;
   logic [VALUE_W-1:0] sum_sub;
   logic [POS_W-1:0]   chan_off;
   logic               in_chan;
   logic               accept;
   logic               cmd_want;
   logic [VALUE_W-1:0] rx_sum;

   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;

   assign pos      = req_item.frame_start ? '0 : pos_ff;
   assign sum      = req_item.frame_start ? SUM_INIT : sum_ff;
   assign sum_sub  = sum - {{(VALUE_W - BYTE_W){1'b0}}, req_item.rx_byte};
   assign chan_off = pos - POS_W'(2);
   assign in_chan  = (pos >= POS_W'(2)) && ({1'b0, pos} < CHAN_END);
   assign rx_sum   = {req_item.rx_byte, hold_ff};

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      hold_in   = hold_ff;
      cmd_want  = 1'b0;
      cmd.op    = CMD_WRITE;
      cmd.index = chan_off[POS_W-1:1];
      cmd.value = {req_item.rx_byte, hold_ff};

      if (pos < PAYLOAD_END) begin
         if (in_chan) begin
            // Channel bytes alternate low, high; the pair is written on the high byte.
            if (!chan_off[0]) begin
               hold_in = req_item.rx_byte;
            end else begin
               cmd_want = 1'b1;
            end
         end
      end else if (pos == PAYLOAD_END) begin
         hold_in = req_item.rx_byte;
      end

      if (pos >= LAST_POS) begin
         pos_in = '0;
         sum_in = SUM_INIT;
         if (rx_sum == sum) begin
            cmd_want = 1'b1;
            cmd.op   = CMD_EMIT;
         end
      end else begin
         pos_in = pos + POS_W'(1);
         sum_in = (pos < PAYLOAD_END) ? sum_sub : sum;
      end
   end

   assign cmd_valid = accept && cmd_want;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= SUM_INIT;
         hold_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         hold_ff <= hold_in;
      end
   end

endmodule

### src/ibfd_queue.sv
module ibfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ibfd_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ibfd_pkg::cmd_type pop_data
);
   import ibfd_pkg::*;

   cmd_type entry_ff [QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/ibfd_back.sv
module ibfd_back #(
   parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  ibfd_pkg::cmd_type      cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ibfd_pkg::rsp_item_type rsp_item
);
   import ibfd_pkg::*;

   localparam int unsigned IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam logic [CHANNEL_W-1:0] LAST_INDEX = CHANNEL_W'(CHANNEL_COUNT - 1);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   logic [VALUE_W-1:0] store_ff [CHANNEL_COUNT];

   state_type            state_ff, state_in;
   logic [CHANNEL_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic                 out_free;
   logic                 store_wr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Pending writes wait in the queue until the current burst has read the store.
   assign cmd_ready = (state_ff == ST_IDLE);
   assign store_wr  = cmd_valid && cmd_ready && (cmd.op == CMD_WRITE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op == CMD_EMIT) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.channel_index = cnt_ff;
               rsp_item_in.channel_value = store_ff[cnt_ff[IDX_W-1:0]];
               rsp_item_in.last_channel  = (cnt_ff == LAST_INDEX);
               cnt_in                    = cnt_ff + CHANNEL_W'(1);
               if (cnt_ff == LAST_INDEX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[cmd.index[IDX_W-1:0]] <= cmd.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### src/ibus_frame_decoder_top.sv
// Decodes a 32-byte i-bus servo frame fed one byte per item, with frame_start
// marking byte 0. The front takes one byte per cycle while req_ready is high,
// keeps the running checksum, and queues a write for each completed channel
// and an emit command when the received checksum matches; a bad frame
// yields no items. The back owns the channel store and, on an emit, sends
// the channel items in order, one per cycle while rsp_ready is high, the
// final one with last_channel set. During that burst channel writes of the
// next frame wait in a 4-entry command queue, so the front keeps taking
// bytes at one per cycle until that queue fills; the queue depth and the
// burst length set when req_ready drops.
module ibus_frame_decoder_top #(
   parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEF,
   parameter int unsigned FRAME_BYTES   = ibfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ibfd_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ibfd_pkg::rsp_item_type rsp_item
);
   import ibfd_pkg::*;

   cmd_type front_cmd;
   logic    front_cmd_valid;
   logic    front_cmd_ready;
   cmd_type back_cmd;
   logic    back_cmd_valid;
   logic    back_cmd_ready;

   ibfd_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .FRAME_BYTES   (FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cmd_valid (front_cmd_valid),
      .cmd_ready (front_cmd_ready),
      .cmd       (front_cmd)
   );

   ibfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_cmd_valid),
      .push_ready (front_cmd_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_cmd_valid),
      .pop_ready  (back_cmd_ready),
      .pop_data   (back_cmd)
   );

   ibfd_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_cmd_valid),
      .cmd_ready (back_cmd_ready),
      .cmd       (back_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

### tb/sv/tb_ibus_frame_decoder_top.sv
module tb_ibus_frame_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ibfd_pkg::*;

   localparam int NUM_CHANNELS    = CHANNEL_COUNT_DEF;
   localparam int FRAME_LEN       = FRAME_BYTES_DEF;
   localparam int CHECK_LOW_POS   = FRAME_LEN - 2;
   localparam int RANDOM_ITEMS    = 280;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 30;
   localparam int REPORT_LINES    = 40;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef enum int {
      FRAME_GOOD,
      FRAME_NO_START,
      FRAME_BAD_SUM,
      FRAME_CUT,
      LINE_NOISE
   } frame_kind_type;

   typedef logic [VALUE_W-1:0] channel_set_type [NUM_CHANNELS];

   class channel_frame_tracker;
      logic [POS_W-1:0]   byte_pos;
      logic [VALUE_W-1:0] frame_sum;
      logic [BYTE_W-1:0]  low_hold;
      logic [VALUE_W-1:0] channel_value [NUM_CHANNELS];
      rsp_item_type       expected_channels [$];
      int unsigned        mismatch_count;
      int unsigned        frames_decoded;
      int unsigned        frames_rejected;
      int unsigned        channels_checked;

      function new();
         byte_pos  = '0;
         frame_sum = SUM_INIT;
         low_hold  = '0;
         foreach (channel_value[i]) channel_value[i] = '0;
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         // Only the first few are printed so a broken block cannot flood the log.
         if (mismatch_count <= REPORT_LINES) begin
            $display("mismatch at %0t: %s", $time, what);
         end
      endtask

      function void note_byte(req_item_type it);
         int unsigned        pos;
         logic [VALUE_W-1:0] sum;
         rsp_item_type       want;
         int                 k;
         pos = it.frame_start ? 0 : byte_pos;
         sum = it.frame_start ? SUM_INIT : frame_sum;
         if (pos < CHECK_LOW_POS) begin
            sum = sum - it.rx_byte;
            if (pos >= 2 && pos < 2 + 2 * NUM_CHANNELS) begin
               if (pos % 2 == 0) begin
                  low_hold = it.rx_byte;
               end else begin
                  channel_value[(pos - 2) / 2] = {it.rx_byte, low_hold};
               end
            end
         end else if (pos == CHECK_LOW_POS) begin
            low_hold = it.rx_byte;
         end
         if (pos >= FRAME_LEN - 1) begin
            if ({it.rx_byte, low_hold} == sum) begin
               for (k = 0; k < NUM_CHANNELS; k++) begin
                  want.channel_index = CHANNEL_W'(k);
                  want.channel_value = channel_value[k];
                  want.last_channel  = (k == NUM_CHANNELS - 1);
                  expected_channels.push_back(want);
               end
               frames_decoded++;
            end else begin
               frames_rejected++;
            end
            // The position and the sum restart whether or not the frame passed.
            byte_pos  = '0;
            frame_sum = SUM_INIT;
         end else begin
            byte_pos  = POS_W'(pos + 1);
            frame_sum = sum;
         end
      endfunction

      task check_channel(rsp_item_type got);
         rsp_item_type want;
         if (expected_channels.size() == 0) begin
            report_mismatch($sformatf("unexpected item: channel %0d value %04h last %0b",
                                      got.channel_index, got.channel_value,
                                      got.last_channel));
            return;
         end
         want = expected_channels.pop_front();
         channels_checked++;
         if (got.channel_index !== want.channel_index) begin
            report_mismatch($sformatf("channel_index %0d, expected %0d",
                                      got.channel_index, want.channel_index));
         end
         if (got.channel_value !== want.channel_value) begin
            report_mismatch($sformatf("channel %0d value %04h, expected %04h",
                                      want.channel_index, got.channel_value,
                                      want.channel_value));
         end
         if (got.last_channel !== want.last_channel) begin
            report_mismatch($sformatf("channel %0d last_channel %0b, expected %0b",
                                      want.channel_index, got.last_channel,
                                      want.last_channel));
         end
      endtask

      task check_drained();
         if (expected_channels.size() != 0) begin
            report_mismatch($sformatf("%0d expected channel items never came out",
                                      expected_channels.size()));
            expected_channels.delete();
         end
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_left      = 0;
   int unsigned cycle_count    = 0;
   int unsigned items_sent     = 0;

   channel_frame_tracker frame_tracker = new();

   ibus_frame_decoder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

   // The receiver stalls at random, or holds off completely while hold_left runs down.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         frame_tracker.check_channel(rsp_item);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic start);
      req_item_type it;
      it.rx_byte     = value;
      it.frame_start = start;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      frame_tracker.note_byte(it);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_tracker.expected_channels.size() != 0);
   endtask

   task automatic fill_channels(output channel_set_type chans);
      int k;
      for (k = 0; k < NUM_CHANNELS; k++) begin
         case ($urandom_range(7))
            0:       chans[k] = '0;
            1:       chans[k] = '1;
            2:       chans[k] = VALUE_W'($urandom_range(2000, 1000));
            default: chans[k] = VALUE_W'($urandom_range(16'hFFFF));
         endcase
      end
   endtask

   task automatic send_frame(input frame_kind_type kind, input channel_set_type chans,
                             input logic [BYTE_W-1:0] hdr0, input logic [BYTE_W-1:0] hdr1,
                             input int unsigned cut_len);
      logic [BYTE_W-1:0]  frame_bytes [FRAME_LEN];
      logic [VALUE_W-1:0] sum;
      int unsigned        length;
      int                 k;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      frame_bytes[0] = hdr0;
      frame_bytes[1] = hdr1;
      for (k = 0; k < NUM_CHANNELS; k++) begin
         frame_bytes[2 + 2 * k] = chans[k][7:0];
         frame_bytes[3 + 2 * k] = chans[k][15:8];
      end
      sum = SUM_INIT;
      for (k = 0; k < CHECK_LOW_POS; k++) begin
         sum = sum - frame_bytes[k];
      end
      // A nonzero flip pattern guarantees the checksum no longer matches.
      if (kind == FRAME_BAD_SUM) begin
         sum = sum ^ VALUE_W'($urandom_range(16'hFFFF, 1));
      end
      frame_bytes[CHECK_LOW_POS] = sum[7:0];
      frame_bytes[FRAME_LEN - 1] = sum[15:8];
      length = (kind == FRAME_CUT) ? cut_len : FRAME_LEN;
      for (k = 0; k < length; k++) begin
         send_byte(frame_bytes[k], (k == 0) && (kind != FRAME_NO_START));
      end
   endtask

   initial begin
      channel_set_type   chans;
      frame_kind_type    kind;
      int                phase;
      int                r;
      int                noise_len;
      int                i;
      int unsigned       phase_end;
      logic [BYTE_W-1:0] hdr0;
      logic [BYTE_W-1:0] hdr1;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Channel values at the extremes and at the byte and sign boundaries.
      chans = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h0001,
                16'hFFFE, 16'h5555, 16'hAAAA, 16'h03E8, 16'h07D0, 16'h05DC, 16'h0000};
      send_frame(FRAME_GOOD, chans, 8'h20, 8'h40, FRAME_LEN);
      // A frame broken off after a few bytes, realigned by the next frame start.
      fill_channels(chans);
      send_frame(FRAME_CUT, chans, 8'hFF, 8'h00, 5);

      for (phase = 0; phase < 4; phase++) begin
         wait_for_results();
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               // Long output hold-off so the command queue fills and req_ready drops.
               hold_left <= HOLD_OFF_CYCLES;
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 81;
            end
            default: begin
               send_idle_pct  = 28;
               recv_stall_pct = 28;
            end
         endcase
         phase_end = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < phase_end) begin
            r = $urandom_range(99);
            if (r < 60) begin
               kind = FRAME_GOOD;
            end else if (r < 72) begin
               kind = FRAME_NO_START;
            end else if (r < 82) begin
               kind = FRAME_BAD_SUM;
            end else if (r < 91) begin
               kind = FRAME_CUT;
            end else begin
               kind = LINE_NOISE;
            end
            // Without a start flag a frame only lines up when the block sits at byte 0.
            if (kind == FRAME_NO_START && frame_tracker.byte_pos != 0) begin
               kind = FRAME_GOOD;
            end
            if (kind == LINE_NOISE) begin
               noise_len = $urandom_range(6, 1);
               for (i = 0; i < noise_len; i++) begin
                  send_byte(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0);
               end
            end else begin
               if ($urandom_range(3) == 0) begin
                  hdr0 = BYTE_W'($urandom_range(255));
                  hdr1 = BYTE_W'($urandom_range(255));
               end else begin
                  hdr0 = 8'h20;
                  hdr1 = 8'h40;
               end
               fill_channels(chans);
               send_frame(kind, chans, hdr0, hdr1, $urandom_range(FRAME_LEN - 1, 1));
            end
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      frame_tracker.check_drained();

      $display("Fed %0d bytes over four idling phases: %0d frames decoded, %0d bad checksums.",
               items_sent, frame_tracker.frames_decoded, frame_tracker.frames_rejected);
      $display("Checked %0d channel items, with a %0d-cycle output hold-off, in %0d cycles.",
               frame_tracker.channels_checked, HOLD_OFF_CYCLES, cycle_count);
      if (frame_tracker.mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
